// ===== design/tlsa_pkg.sv =====
// Package for the Thumb logical and shift unit.
// Holds the operation codes, field widths and the result bundle type.
// No dependencies.
package tlsa_pkg;

	localparam int DATA_W    = 32;
	localparam int CMD_W     = 4;
	localparam int IMM_W     = 5;
	localparam int REG_AMT_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_AND     = 4'd0,
		CMD_BIC     = 4'd1,
		CMD_EOR     = 4'd2,
		CMD_ORR     = 4'd3,
		CMD_MVN     = 4'd4,
		CMD_ASR_IMM = 4'd5,
		CMD_ASR_REG = 4'd6,
		CMD_LSL_IMM = 4'd7,
		CMD_LSR_IMM = 4'd8,
		CMD_LSL_REG = 4'd9,
		CMD_LSR_REG = 4'd10,
		CMD_ROR_REG = 4'd11
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              n;
		logic              z;
		logic              c;
	} res_t;

endpackage

// ===== design/thumb_logic_shift_alu.sv =====
// Thumb logical and shift unit: input register, datapath, result register.
// An accepted beat is held in the input register, and its result is then registered
// in the result register, from which it is shown on the outputs.
// Throughput: one beat per cycle unless out_stall holds the result register; the shifter
// and logic sit in one stage between the input register and the result register.
// Reset clears both stage valid bits; payload registers are not reset.
// Depends on tlsa_pkg and tlsa_exec.
module thumb_logic_shift_alu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tlsa_pkg::CMD_W-1:0]  cmd,
	input  logic [tlsa_pkg::DATA_W-1:0] operand_a,
	input  logic [tlsa_pkg::DATA_W-1:0] operand_b,
	input  logic [tlsa_pkg::IMM_W-1:0]  shift_imm,
	input  logic                        carry_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tlsa_pkg::DATA_W-1:0] result,
	output logic                        flag_n,
	output logic                        flag_z,
	output logic                        flag_c
);
	import tlsa_pkg::*;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [DATA_W-1:0] a_s1;
	logic [DATA_W-1:0] b_s1;
	logic [IMM_W-1:0]  imm_s1;
	logic              cin_s1;
	logic              valid_s2;
	res_t              res_s2;
	res_t              res_comb;
	logic              load_s2;
	logic              load_s1;

	// The result register takes a new beat whenever it is empty or being drained.
	assign load_s2  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			cmd_s1 <= cmd;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
			imm_s1 <= shift_imm;
			cin_s1 <= carry_in;
		end
		if (load_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	tlsa_exec u_exec (
		.cmd       (cmd_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.shift_imm (imm_s1),
		.carry_in  (cin_s1),
		.res       (res_comb)
	);

	assign out_valid = valid_s2;
	assign result    = res_s2.value;
	assign flag_n    = res_s2.n;
	assign flag_z    = res_s2.z;
	assign flag_c    = res_s2.c;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while a stage had room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted beat did not reach the input register");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_s2) |=> out_valid)
		else $error("beat in the input register was lost on its way out");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (flag_z == (result == '0)) && (flag_n == result[DATA_W-1]))
		else $error("N or Z flag disagrees with the result value");

endmodule

// ===== design/tlsa_exec.sv =====
// Combinational datapath of the Thumb logical and shift unit.
// Computes the result value and the N, Z and C flags for one beat.
// Depends on tlsa_pkg.
module tlsa_exec (
	input  logic [tlsa_pkg::CMD_W-1:0]  cmd,
	input  logic [tlsa_pkg::DATA_W-1:0] operand_a,
	input  logic [tlsa_pkg::DATA_W-1:0] operand_b,
	input  logic [tlsa_pkg::IMM_W-1:0]  shift_imm,
	input  logic                        carry_in,
	output tlsa_pkg::res_t              res
);
	import tlsa_pkg::*;

	logic [REG_AMT_W-1:0] amt;
	logic                 amt_zero;
	logic                 amt_small;
	logic                 amt_is_32;
	logic [IMM_W-1:0]     sh_n;
	logic [DATA_W-1:0]    fill;
	logic [DATA_W-1:0]    sra_v;
	logic [DATA_W-1:0]    srl_v;
	logic [DATA_W-1:0]    sll_v;
	logic [DATA_W-1:0]    ror_v;
	logic [2*DATA_W-1:0]  ror_wide;
	logic                 c_right;
	logic                 c_left;
	logic [DATA_W-1:0]    r;
	logic                 c;

	assign amt       = operand_b[REG_AMT_W-1:0];
	assign amt_zero  = (amt == '0);
	assign amt_small = (amt[REG_AMT_W-1:IMM_W] == '0);
	assign amt_is_32 = (amt == REG_AMT_W'(DATA_W));

	// One shared shift amount: register forms use the low five bits of the byte.
	assign sh_n = (cmd == CMD_ASR_IMM || cmd == CMD_LSL_IMM || cmd == CMD_LSR_IMM) ?
		shift_imm : amt[IMM_W-1:0];

	assign fill     = {DATA_W{operand_a[DATA_W-1]}};
	assign sra_v    = $unsigned($signed(operand_a) >>> sh_n);
	assign srl_v    = operand_a >> sh_n;
	assign sll_v    = operand_a << sh_n;
	assign ror_wide = {operand_a, operand_a} >> sh_n;
	assign ror_v    = ror_wide[DATA_W-1:0];

	// Last bit out: bit n-1 for right shifts, bit 32-n for left shifts (n nonzero).
	assign c_right = operand_a[sh_n - IMM_W'(1)];
	assign c_left  = operand_a[IMM_W'(0) - sh_n];

	always_comb begin
		r = operand_a;
		c = carry_in;
		case (cmd_t'(cmd))
			CMD_AND: r = operand_a & operand_b;
			CMD_BIC: r = operand_a & ~operand_b;
			CMD_EOR: r = operand_a ^ operand_b;
			CMD_ORR: r = operand_a | operand_b;
			CMD_MVN: r = ~operand_b;
			CMD_ASR_IMM: begin
				if (shift_imm == '0) begin
					r = fill;
					c = operand_a[DATA_W-1];
				end else begin
					r = sra_v;
					c = c_right;
				end
			end
			CMD_ASR_REG: begin
				if (amt_zero) begin
					r = operand_a;
				end else if (amt_small) begin
					r = sra_v;
					c = c_right;
				end else begin
					r = fill;
					c = operand_a[DATA_W-1];
				end
			end
			CMD_LSL_IMM: begin
				if (shift_imm != '0) begin
					r = sll_v;
					c = c_left;
				end
			end
			CMD_LSR_IMM: begin
				if (shift_imm == '0) begin
					r = '0;
					c = operand_a[DATA_W-1];
				end else begin
					r = srl_v;
					c = c_right;
				end
			end
			CMD_LSL_REG: begin
				if (amt_zero) begin
					r = operand_a;
				end else if (amt_small) begin
					r = sll_v;
					c = c_left;
				end else if (amt_is_32) begin
					r = '0;
					c = operand_a[0];
				end else begin
					r = '0;
					c = 1'b0;
				end
			end
			CMD_LSR_REG: begin
				if (amt_zero) begin
					r = operand_a;
				end else if (amt_small) begin
					r = srl_v;
					c = c_right;
				end else if (amt_is_32) begin
					r = '0;
					c = operand_a[DATA_W-1];
				end else begin
					r = '0;
					c = 1'b0;
				end
			end
			CMD_ROR_REG: begin
				// A nonzero multiple of 32 leaves the value as is; C still follows bit 31.
				if (!amt_zero) begin
					r = ror_v;
					c = ror_v[DATA_W-1];
				end
			end
			default: begin
				r = operand_a;
			end
		endcase
	end

	assign res.value = r;
	assign res.n     = r[DATA_W-1];
	assign res.z     = (r == '0);
	assign res.c     = c;

endmodule
